>>> design/ple_pkg.sv
package ple_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_READ   = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

  localparam int OP_BITS    = 2;
  localparam int POS_BITS   = 7;
  localparam int WORD_BITS  = 32;
  localparam int STAT_BITS  = 2;
  localparam int TDATA_BITS = 48;

  // Request fields as they sit in the input tdata.
  typedef struct packed {
    logic [TDATA_BITS-OP_BITS-POS_BITS-WORD_BITS-1:0] pad;
    logic [WORD_BITS-1:0]                              value_in;
    logic [POS_BITS-1:0]                               position;
    op_t                                               op;
  } req_t;

  // Result fields as they sit in the output tdata.
  typedef struct packed {
    logic [TDATA_BITS-STAT_BITS-WORD_BITS-POS_BITS-1:0] pad;
    logic [POS_BITS-1:0]                                length;
    logic [WORD_BITS-1:0]                               value_out;
    status_t                                            status;
  } rsp_t;

endpackage

>>> design/ple_ram.sv
module ple_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/positional_list_engine.sv
// Throughput: one request at a time; the shift moves one entry per cycle through the
// single-port-write list memory (read of one entry overlapped with the write of the last).
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// the memory contents are not cleared.
module positional_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op[1:0], position[8:2], value_in[40:9], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], value_out[33:2], length[40:34], zero pad
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ple_pkg::POS_BITS) ? CW : ple_pkg::POS_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_INSFIN = 3'd3;
  localparam logic [2:0] S_REM    = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ple_pkg::rsp_t         rsp_r, rsp_nxt;

  ple_pkg::req_t         req;
  logic                  accept;
  logic [CMPW-1:0]       pos_c, cnt_c;
  logic [VALUE_BITS-1:0] vin_store;
  logic [31:0]           rd_word;

  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata;

  logic                  fin;
  ple_pkg::status_t      fin_status;
  logic [31:0]           fin_value;
  logic [CW-1:0]         fin_count;

  ple_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(VALUE_BITS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign req       = ple_pkg::req_t'(in_tdata);
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign pos_c     = CMPW'(req.position);
  assign cnt_c     = CMPW'(count_r);
  assign vin_store = VALUE_BITS'(64'(signed'(req.value_in)));
  assign rd_word   = 32'(64'(signed'(rdata)));

  // The shift reads one entry ahead of the write, always at a different address
  // in the direction of travel, so no forwarding is needed.
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    ptr_nxt    = ptr_r;
    val_nxt    = val_r;
    we         = 1'b0;
    waddr      = ptr_r;
    wdata      = rdata;
    re         = 1'b0;
    raddr      = ptr_r;
    fin        = 1'b0;
    fin_status = ple_pkg::ST_OK;
    fin_value  = '0;
    fin_count  = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req.op)
            ple_pkg::OP_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                fin        = 1'b1;
                fin_status = ple_pkg::ST_FULL;
              end else if (pos_c > cnt_c) begin
                fin        = 1'b1;
                fin_status = ple_pkg::ST_RANGE;
              end else if (pos_c == cnt_c) begin
                we        = 1'b1;
                waddr     = AW'(req.position);
                wdata     = vin_store;
                fin       = 1'b1;
                fin_count = count_r + CW'(1);
              end else begin
                re        = 1'b1;
                raddr     = AW'(count_r - CW'(1));
                ptr_nxt   = AW'(count_r - CW'(1));
                pos_nxt   = AW'(req.position);
                val_nxt   = vin_store;
                state_nxt = S_INS;
              end
            end
            ple_pkg::OP_READ, ple_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                fin        = 1'b1;
                fin_status = ple_pkg::ST_EMPTY;
              end else if (pos_c >= cnt_c) begin
                fin        = 1'b1;
                fin_status = ple_pkg::ST_RANGE;
              end else if (req.op == ple_pkg::OP_READ) begin
                re        = 1'b1;
                raddr     = AW'(req.position);
                state_nxt = S_READ;
              end else if (pos_c == cnt_c - CMPW'(1)) begin
                fin       = 1'b1;
                fin_count = count_r - CW'(1);
              end else begin
                re        = 1'b1;
                raddr     = AW'(req.position) + AW'(1);
                ptr_nxt   = AW'(req.position) + AW'(1);
                state_nxt = S_REM;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin       = 1'b1;
        fin_value = rd_word;
        state_nxt = S_IDLE;
      end
      S_INS: begin
        we    = 1'b1;
        waddr = ptr_r + AW'(1);
        if (ptr_r == pos_r) begin
          state_nxt = S_INSFIN;
        end else begin
          re      = 1'b1;
          raddr   = ptr_r - AW'(1);
          ptr_nxt = ptr_r - AW'(1);
        end
      end
      S_INSFIN: begin
        we        = 1'b1;
        waddr     = pos_r;
        wdata     = val_r;
        fin       = 1'b1;
        fin_count = count_r + CW'(1);
        state_nxt = S_IDLE;
      end
      S_REM: begin
        we    = 1'b1;
        waddr = ptr_r - AW'(1);
        if (ptr_r == AW'(count_r - CW'(1))) begin
          fin       = 1'b1;
          fin_count = count_r - CW'(1);
          state_nxt = S_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt     = fin_count;
    out_valid_nxt = out_valid_r && !out_tready;
    rsp_nxt       = rsp_r;
    if (fin) begin
      out_valid_nxt     = 1'b1;
      rsp_nxt.pad       = '0;
      rsp_nxt.status    = fin_status;
      rsp_nxt.value_out = fin_value;
      rsp_nxt.length    = ple_pkg::POS_BITS'(fin_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    ptr_r <= ptr_nxt;
    val_r <= val_nxt;
    rsp_r <= rsp_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 48'(rsp_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
    (count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_count_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_valid_r)
    else $error("entry count changed without a result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE) || out_valid_r)
    else $error("accepted request left neither work nor result");

endmodule

>>> tb/positional_list_engine_tb.sv
module positional_list_engine_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP = 64;
  localparam int STALL_LIMIT = 2000;
  // Op code that the block ignores.
  localparam ple_pkg::op_t OP_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  positional_list_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the list held by the block.
  logic [31:0]    list_words[LIST_CAP];
  int             list_len;
  ple_pkg::rsp_t  pending_rsp[$];
  int             err_count;
  bit             idle_on;
  bit             timed_out;
  int             quiet_cycles;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Applies one request to the shadow list and returns the result it should give.
  function automatic ple_pkg::rsp_t list_apply(input ple_pkg::op_t op, input int pos,
                                               input logic [31:0] val);
    ple_pkg::rsp_t r;
    r = '0;
    r.status = ple_pkg::ST_OK;
    if (op == ple_pkg::OP_INSERT) begin
      if (list_len >= LIST_CAP) r.status = ple_pkg::ST_FULL;
      else if (pos > list_len) r.status = ple_pkg::ST_RANGE;
      else begin
        for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
        list_words[pos] = val;
        list_len++;
      end
    end else if (op == ple_pkg::OP_READ || op == ple_pkg::OP_REMOVE) begin
      if (list_len == 0) r.status = ple_pkg::ST_EMPTY;
      else if (pos >= list_len) r.status = ple_pkg::ST_RANGE;
      else if (op == ple_pkg::OP_READ) r.value_out = list_words[pos];
      else begin
        for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
        list_len--;
      end
    end
    r.length = list_len[6:0];
    return r;
  endfunction

  // The valid stays high after a transaction unless an idle gap follows.
  task automatic send_request(input ple_pkg::op_t op, input int pos, input logic [31:0] val);
    ple_pkg::req_t q;
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    q = '0;
    q.op = op;
    q.position = pos[6:0];
    q.value_in = val;
    in_tdata  <= q;
    in_tvalid <= 1'b1;
    pending_rsp.push_back(list_apply(op, pos, val));
    do @(posedge clk); while (!in_tready);
  endtask

  // Result side: random backpressure while idle gaps are on, compare every transaction.
  initial begin
    ple_pkg::rsp_t got, want;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], '0);
        end else begin
          want = pending_rsp.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.value_out != want.value_out)
            report_mismatch("value_out", got.value_out, want.value_out);
          if (got.length != want.length)
            report_mismatch("length", 32'(got.length), 32'(want.length));
        end
      end
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_tready <= 1'b1;
      end else out_tready <= 1'b1;
    end
  end

  // Watchdog: counts cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("positional_list_engine_tb: FAIL");
      $finish;
    end
  end

  task automatic test_empty_list;
    send_request(ple_pkg::OP_READ, 0, '0);
    send_request(ple_pkg::OP_REMOVE, 0, '0);
    send_request(OP_NONE, 5, 32'h1234_5678);
  endtask

  task automatic test_directed_edges;
    send_request(ple_pkg::OP_INSERT, 1, 32'h1);
    send_request(ple_pkg::OP_INSERT, 0, 32'h7fff_ffff);
    send_request(ple_pkg::OP_INSERT, 0, 32'h8000_0000);
    send_request(ple_pkg::OP_INSERT, 2, 32'hffff_ffff);
    send_request(ple_pkg::OP_INSERT, 1, 32'h0);
    send_request(ple_pkg::OP_READ, 0, 32'hffff_ffff);
    send_request(ple_pkg::OP_READ, 3, '0);
    send_request(ple_pkg::OP_READ, 4, '0);
    send_request(ple_pkg::OP_READ, 127, '0);
    send_request(ple_pkg::OP_REMOVE, 4, '0);
    send_request(ple_pkg::OP_REMOVE, 1, '0);
    send_request(ple_pkg::OP_REMOVE, 3, '0);
    send_request(OP_NONE, 127, 32'hffff_ffff);
  endtask

  // Fills to capacity, probes the full case, then drains from both ends.
  task automatic test_fill_drain;
    while (list_len < LIST_CAP)
      send_request(ple_pkg::OP_INSERT, $urandom_range(0, list_len), $urandom);
    send_request(ple_pkg::OP_INSERT, 0, $urandom);
    send_request(ple_pkg::OP_INSERT, 100, $urandom);
    send_request(ple_pkg::OP_READ, 63, '0);
    send_request(ple_pkg::OP_READ, 64, '0);
    while (list_len > 0)
      send_request(ple_pkg::OP_REMOVE, ($urandom_range(0, 1) ? list_len - 1 : 0), '0);
  endtask

  task automatic test_random_ops(input int n);
    int pick, pos;
    ple_pkg::op_t op;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = ple_pkg::OP_INSERT;
      else if (pick < 70) op = ple_pkg::OP_READ;
      else if (pick < 96) op = ple_pkg::OP_REMOVE;
      else op = OP_NONE;
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 127);
      else pos = $urandom_range(0, list_len);
      send_request(op, pos, $urandom);
    end
  endtask

  initial begin
    int drain;
    err_count = 0;
    list_len = 0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_directed_edges();
    test_fill_drain();
    test_random_ops(300);
    idle_on = 1'b0;
    test_random_ops(150);
    in_tvalid <= 1'b0;
    drain = 0;
    while (pending_rsp.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (80) @(posedge clk);
    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("positional_list_engine_tb: PASS");
    end else begin
      $display("positional_list_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
